/* rtl/ipnm_pkg.sv */
// ----------------------------------------------------------------------------
// ipnm_pkg
// Shared types and constants for the IPv4 prefix netmap rewrite block.
// ----------------------------------------------------------------------------
package ipnm_pkg;

  localparam logic [3:0]  IPV4_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
  localparam logic [15:0] UDP_CSUM_ALL_ONES = 16'hFFFF;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [15:0] FRAG_BITS        = 16'h3FFF;

  // Register index, taken from paddr[2]
  localparam logic REG_FROM_NETMASK = 1'b0;
  localparam logic REG_TO_NETWORK   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_FRAG     = 2'd2,
    ST_L4_SHORT = 2'd3
  } ipnm_status_e;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  ip_version;
    logic [3:0]  header_words;
    logic [15:0] frag_field;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic        partial_mode;
    logic        l4_header_present;
  } ipnm_in_t;

  typedef struct packed {
    ipnm_status_e status;
    logic [31:0]  new_src_addr;
    logic [31:0]  new_dst_addr;
    logic [15:0]  new_ip_checksum;
    logic [15:0]  new_l4_checksum;
    logic         rewritten;
  } ipnm_out_t;

  typedef struct packed {
    logic [31:0] from_netmask;
    logic [31:0] to_network;
  } ipnm_cfg_t;

endpackage

/* rtl/ipnm_csum_upd.sv */
// ----------------------------------------------------------------------------
// ipnm_csum_upd
// Incremental one's-complement checksum update for a 32-bit field change.
// ----------------------------------------------------------------------------
module ipnm_csum_upd (
  input  logic [15:0] check_i,
  input  logic [31:0] old_i,
  input  logic [31:0] new_i,
  input  logic        partial_i,
  output logic [15:0] check_o
);

  logic [31:0] chk32;
  logic [32:0] sum1;
  logic [31:0] acc1;
  logic [32:0] sum2;
  logic [31:0] acc2;
  logic [16:0] fold1;
  logic [16:0] fold2;

  always_comb begin
    // Partial offload keeps the pseudo sum uncomplemented
    chk32 = partial_i ? {16'h0000, check_i} : ~{16'h0000, check_i};
    sum1  = {1'b0, chk32} + {1'b0, ~old_i};
    acc1  = sum1[31:0] + {31'd0, sum1[32]};
    sum2  = {1'b0, acc1} + {1'b0, new_i};
    acc2  = sum2[31:0] + {31'd0, sum2[32]};
    fold1 = {1'b0, acc2[15:0]} + {1'b0, acc2[31:16]};
    fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    check_o = partial_i ? fold2[15:0] : ~fold2[15:0];
  end

endmodule

/* rtl/ipnm_cfg.sv */
// ----------------------------------------------------------------------------
// ipnm_cfg
// APB register file holding the netmask and target network prefix.
// ----------------------------------------------------------------------------
module ipnm_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ipnm_pkg::ipnm_cfg_t cfg_o
);
  import ipnm_pkg::*;

  logic [31:0] from_netmask_q, from_netmask_d;
  logic [31:0] to_network_q, to_network_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    from_netmask_d = from_netmask_q;
    to_network_d   = to_network_q;
    if (wr_en) begin
      case (paddr[2])
        REG_FROM_NETMASK: from_netmask_d = pwdata;
        REG_TO_NETWORK:   to_network_d   = pwdata;
        default:          from_netmask_d = from_netmask_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_netmask_q <= 32'd0;
      to_network_q   <= 32'd0;
    end else begin
      from_netmask_q <= from_netmask_d;
      to_network_q   <= to_network_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FROM_NETMASK: prdata = from_netmask_q;
      REG_TO_NETWORK:   prdata = to_network_q;
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg_o.from_netmask = from_netmask_q;
  assign cfg_o.to_network   = to_network_q;

endmodule

/* rtl/ipnm_core.sv */
// ----------------------------------------------------------------------------
// ipnm_core
// Header checks, address mapping and checksum fix-up for one header.
// ----------------------------------------------------------------------------
module ipnm_core (
  input  ipnm_pkg::ipnm_in_t  hdr_i,
  input  ipnm_pkg::ipnm_cfg_t cfg_i,
  output ipnm_pkg::ipnm_out_t res_o
);
  import ipnm_pkg::*;

  logic        hdr_bad;
  logic        is_frag;
  logic        is_tcp;
  logic        is_udp;
  logic [31:0] old_a;
  logic [31:0] new_a;
  logic        changed;
  logic [15:0] ip_upd;
  logic [15:0] l4_upd;
  logic        do_rewrite;

  assign hdr_bad = (hdr_i.ip_version != IPV4_VERSION) ||
                   (hdr_i.header_words < MIN_HEADER_WORDS);
  assign is_frag = |(hdr_i.frag_field & FRAG_BITS);
  assign is_tcp  = hdr_i.protocol == PROTO_TCP;
  assign is_udp  = hdr_i.protocol == PROTO_UDP;
  assign old_a   = hdr_i.cmd ? hdr_i.dst_addr : hdr_i.src_addr;
  assign new_a   = cfg_i.to_network | (old_a & ~cfg_i.from_netmask);
  assign changed = new_a != old_a;

  ipnm_csum_upd u_ip_csum (
    .check_i   (hdr_i.ip_checksum),
    .old_i     (old_a),
    .new_i     (new_a),
    .partial_i (1'b0),
    .check_o   (ip_upd)
  );

  ipnm_csum_upd u_l4_csum (
    .check_i   (hdr_i.l4_checksum),
    .old_i     (old_a),
    .new_i     (new_a),
    .partial_i (hdr_i.partial_mode),
    .check_o   (l4_upd)
  );

  always_comb begin
    res_o.status          = ST_OK;
    res_o.new_src_addr    = hdr_i.src_addr;
    res_o.new_dst_addr    = hdr_i.dst_addr;
    res_o.new_ip_checksum = hdr_i.ip_checksum;
    res_o.new_l4_checksum = hdr_i.l4_checksum;
    res_o.rewritten       = 1'b0;
    do_rewrite            = 1'b0;

    if (hdr_bad) begin
      res_o.status = ST_BAD_HDR;
    end else if (is_frag) begin
      res_o.status = ST_FRAG;
    end else if (changed) begin
      if ((is_tcp || is_udp) && !hdr_i.l4_header_present) begin
        res_o.status = ST_L4_SHORT;
      end else begin
        do_rewrite = 1'b1;
      end
    end

    if (do_rewrite) begin
      if (is_tcp) begin
        res_o.new_l4_checksum = l4_upd;
      end else if (is_udp && ((hdr_i.l4_checksum != 16'd0) || hdr_i.partial_mode)) begin
        // zero means "no checksum" for UDP, so never produce it
        res_o.new_l4_checksum = (l4_upd == 16'd0) ? UDP_CSUM_ALL_ONES : l4_upd;
      end
      res_o.new_ip_checksum = ip_upd;
      if (hdr_i.cmd) begin
        res_o.new_dst_addr = new_a;
      end else begin
        res_o.new_src_addr = new_a;
      end
      res_o.rewritten = 1'b1;
    end

    if (!is_tcp && !is_udp) begin
      res_o.new_l4_checksum = 16'd0;
    end
  end

endmodule

/* rtl/ipv4_prefix_netmap_rewrite.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_netmap_rewrite
// Stateless IPv4 prefix rewrite with incremental checksum update.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) carries one IPv4
//   header summary per transaction; the output channel (out_valid_o /
//   out_ready_i / out_data_o) returns exactly one result per input, in order.
//   The APB port programs from_netmask (0x0) and to_network (0x4); program
//   them only while no transaction is in flight.
// Pipeline and throughput:
//   An accepted header lands in the input register, passes the check, map
//   and checksum logic, and is captured in the result register when that
//   register advances, which raises out_valid_o. One header per cycle is
//   sustained while out_ready_i stays high; the two checksum adders sit side
//   by side in the one logic stage.
// Reset:
//   rst_ni clears both valid flags and both configuration registers (which
//   leaves every address unchanged until a register is written nonzero).
// Backpressure:
//   When out_ready_i is low the result register holds its transaction; the
//   input register still fills once, then in_ready_o drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module ipv4_prefix_netmap_rewrite (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ipnm_pkg::ipnm_in_t  in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipnm_pkg::ipnm_out_t out_data_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ipnm_pkg::*;

  ipnm_cfg_t cfg;
  ipnm_out_t res;

  logic      s1_valid_q, s1_valid_d;
  ipnm_in_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  ipnm_out_t out_data_q;
  logic      out_adv;

  ipnm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ipnm_core u_core (
    .hdr_i (s1_data_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Advance the result register when empty or when its transaction is taken
  assign out_adv    = !out_valid_q || out_ready_i;
  // Take a new header when the input register is empty or moves on
  assign in_ready_o = !s1_valid_q || out_adv;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (out_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load only on a real transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
    if (out_adv && s1_valid_q) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A rewrite only ever comes with an OK status
  a_rewrite_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rewritten |-> out_data_q.status == ST_OK)
    else $error("rewrite flagged with non-OK status");

  // Both registers full and output stalled: no room for another header
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline is full");

  // An accepted header always occupies the input register next cycle
  a_accept_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted header lost");

  // A filled input register is moved to the result register when it advances
  a_move_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv |=> out_valid_q)
    else $error("header dropped between stages");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 prefix netmap rewrite block. A queue of
// header transactions feeds a valid/ready driver, an in-bench netmap and
// checksum predictor builds the expected result at every accepted
// transaction, and a monitor compares each returned result field by field.
// The APB port steps through several mask and prefix settings between
// phases, always with the block drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ipnm_pkg::*;

  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  ipnm_in_t    in_data   = '0;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  ipnm_out_t   out_data_o;
  logic [31:0] prdata;
  logic        pready;

  // Bench copy of the two netmap registers, updated after each APB write.
  logic [31:0] nm_mask   = '0;
  logic [31:0] nm_prefix = '0;

  ipnm_in_t  header_q[$];           // headers waiting for the driver
  ipnm_out_t expected_rewrites[$];  // predicted results, oldest first
  ipnm_out_t head_result;
  int        queued_cnt  = 0;
  int        matched_cnt = 0;
  int        error_cnt   = 0;
  bit        steady      = 1'b0;    // set to suppress all idling on both sides

  ipv4_prefix_netmap_rewrite dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: one's complement arithmetic as 32-bit sums with end-around
  // carry, folded to 16 bits at the end.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] eac_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + {31'b0, s[32]};
  endfunction

  // Incremental update for an address swap. In partial mode the field is an
  // uncomplemented pseudo sum, so skip both complements.
  function automatic logic [15:0] csum_adjust(logic [15:0] check, logic [31:0] old_a,
                                              logic [31:0] new_a, logic partial);
    logic [31:0] acc;
    acc = eac_add(partial ? {16'h0, check} : ~{16'h0, check}, ~old_a);
    acc = eac_add(acc, new_a);
    acc = (acc & 32'hFFFF) + (acc >> 16);
    acc = (acc & 32'hFFFF) + (acc >> 16);
    return partial ? acc[15:0] : ~acc[15:0];
  endfunction

  function automatic ipnm_out_t netmap_rewrite(ipnm_in_t h, logic [31:0] mask,
                                               logic [31:0] prefix);
    ipnm_out_t   r;
    logic [31:0] old_a;
    logic [31:0] new_a;
    logic [15:0] l4c;
    logic        is_tcp;
    logic        is_udp;
    r.status          = ST_OK;
    r.new_src_addr    = h.src_addr;
    r.new_dst_addr    = h.dst_addr;
    r.new_ip_checksum = h.ip_checksum;
    r.rewritten       = 1'b0;
    l4c    = h.l4_checksum;
    is_tcp = (h.protocol == PROTO_TCP);
    is_udp = (h.protocol == PROTO_UDP);
    if (h.ip_version != IPV4_VERSION || h.header_words < MIN_HEADER_WORDS) begin
      r.status = ST_BAD_HDR;
    end else if ((h.frag_field & FRAG_BITS) != '0) begin
      r.status = ST_FRAG;
    end else begin
      old_a = h.cmd ? h.dst_addr : h.src_addr;
      new_a = prefix | (old_a & ~mask);
      if (new_a != old_a) begin
        if ((is_tcp || is_udp) && !h.l4_header_present) begin
          r.status = ST_L4_SHORT;
        end else begin
          // A zero UDP checksum means "none" unless the field is a pseudo sum.
          if (is_tcp || (is_udp && (l4c != '0 || h.partial_mode))) begin
            l4c = csum_adjust(l4c, old_a, new_a, h.partial_mode);
            if (is_udp && l4c == '0) l4c = UDP_CSUM_ALL_ONES;
          end
          r.new_ip_checksum = csum_adjust(h.ip_checksum, old_a, new_a, 1'b0);
          if (h.cmd) r.new_dst_addr = new_a;
          else       r.new_src_addr = new_a;
          r.rewritten = 1'b1;
        end
      end
    end
    // No transport checksum outside TCP and UDP.
    r.new_l4_checksum = (is_tcp || is_udp) ? l4c : 16'h0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic bit idle_roll();
    return !steady && ($urandom_range(99, 0) < 6);
  endfunction

  function automatic ipnm_in_t hdr(logic cmd, logic [7:0] proto, logic [31:0] src,
                                   logic [31:0] dst, logic [15:0] ipc, logic [15:0] l4c,
                                   logic partial, logic present);
    ipnm_in_t h;
    h.cmd               = cmd;
    h.ip_version        = IPV4_VERSION;
    h.header_words      = MIN_HEADER_WORDS;
    h.frag_field        = '0;
    h.protocol          = proto;
    h.src_addr          = src;
    h.dst_addr          = dst;
    h.ip_checksum       = ipc;
    h.l4_checksum       = l4c;
    h.partial_mode      = partial;
    h.l4_header_present = present;
    return h;
  endfunction

  // Mostly well-formed TCP/UDP headers with random content; the rest is other
  // protocols, noise, short headers, fragments and bad versions.
  function automatic ipnm_in_t make_header();
    ipnm_in_t     h;
    logic [159:0] noise;
    int           roll;
    roll = $urandom_range(9, 0);
    h = hdr(1'($urandom_range(1, 0)),
            (roll < 4) ? PROTO_TCP : (roll < 8) ? PROTO_UDP : 8'($urandom()),
            $urandom(), $urandom(), 16'($urandom()),
            ($urandom_range(9, 0) == 0) ? 16'h0 : 16'($urandom()),
            1'($urandom_range(1, 0)), $urandom_range(9, 0) != 0);
    h.header_words = 4'($urandom_range(15, 5));
    case ($urandom_range(7, 0))
      0: h.frag_field = 16'h4000;   // DF only
      1: h.frag_field = 16'h8000;   // reserved bit only
      2: h.frag_field = 16'hC000;
      default: h.frag_field = '0;
    endcase
    // Land some addresses inside the target prefix already.
    if ($urandom_range(7, 0) == 0) begin
      if (h.cmd) h.dst_addr = nm_prefix | (h.dst_addr & ~nm_mask);
      else       h.src_addr = nm_prefix | (h.src_addr & ~nm_mask);
    end
    roll = $urandom_range(99, 0);
    if (roll < 6) begin
      noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      h = ipnm_in_t'(noise[$bits(ipnm_in_t)-1:0]);
    end else if (roll < 9) begin
      h.header_words = 4'($urandom_range(4, 0));
    end else if (roll < 12) begin
      h.frag_field = {2'($urandom()), 14'($urandom_range(16'h3FFF, 1))};
    end else if (roll < 13) begin
      h.ip_version = 4'($urandom_range(15, 0));
    end
    return h;
  endfunction

  task automatic queue_header(ipnm_in_t h);
    header_q.push_back(h);
    queued_cnt++;
  endtask

  // Hold until every queued header has come back, then let the pipe settle.
  task automatic drain();
    while (matched_cnt != queued_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle; the register takes the value at
  // the edge that closes the access cycle.
  task automatic apb_write(logic sel_idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel_idx == REG_FROM_NETMASK) nm_mask = value;
    else                             nm_prefix = value;
  endtask

  task automatic set_netmap(logic [31:0] mask, logic [31:0] prefix);
    apb_write(REG_FROM_NETMASK, mask);
    apb_write(REG_TO_NETWORK, prefix);
  endtask

  task automatic log_error(string what, logic [31:0] want, logic [31:0] got);
    error_cnt++;
    if (error_cnt <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) log_error(what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next header when the channel is free, predict the
  // result on acceptance. A presented transaction is never withdrawn.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o)
        expected_rewrites.push_back(netmap_rewrite(in_data, nm_mask, nm_prefix));
      if (!in_valid || in_ready_o) begin
        if (header_q.size() > 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          in_data  <= header_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take each result, compare with the oldest prediction, and
  // stall the output channel at random.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_rewrites.size() == 0) begin
          log_error("result with no header pending (src)", 32'h0, out_data_o.new_src_addr);
        end else begin
          head_result = expected_rewrites.pop_front();
          matched_cnt++;
          check_field("status", 32'(head_result.status), 32'(out_data_o.status));
          check_field("new_src_addr", head_result.new_src_addr, out_data_o.new_src_addr);
          check_field("new_dst_addr", head_result.new_dst_addr, out_data_o.new_dst_addr);
          check_field("new_ip_checksum", 32'(head_result.new_ip_checksum),
                      32'(out_data_o.new_ip_checksum));
          check_field("new_l4_checksum", 32'(head_result.new_l4_checksum),
                      32'(out_data_o.new_l4_checksum));
          check_field("rewritten", 32'(head_result.rewritten), 32'(out_data_o.rewritten));
        end
      end
      out_ready <= !idle_roll();
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, reset-value traffic, directed cases, random phases.
  // --------------------------------------------------------------------------
  initial begin
    ipnm_in_t    h;
    logic [15:0] zero_hit;
    zero_hit = '0;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Registers still at reset: mask and prefix zero, nothing may change.
    repeat (40) queue_header(make_header());
    drain();

    // Directed: remap 10.1.x.x style addresses onto 192.168.0.0/16.
    set_netmap(32'hFFFF_0000, 32'hC0A8_0000);
    queue_header(hdr(1'b0, PROTO_TCP, 32'h0A01_0203, 32'h0808_0808, 16'h1234, 16'hBEEF,
                     1'b0, 1'b1));
    queue_header(hdr(1'b1, PROTO_TCP, 32'h0808_0808, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
                     1'b1, 1'b1));
    queue_header(hdr(1'b0, PROTO_UDP, 32'h0000_0000, 32'h0102_0304, 16'h0000, 16'h5A5A,
                     1'b0, 1'b1));
    // UDP with no checksum: keep it; in partial mode it is a sum, so update.
    queue_header(hdr(1'b1, PROTO_UDP, 32'h0102_0304, 32'h0A0A_0A0A, 16'h4321, 16'h0000,
                     1'b0, 1'b1));
    queue_header(hdr(1'b0, PROTO_UDP, 32'h0A0A_0A0A, 32'h0102_0304, 16'h4321, 16'h0000,
                     1'b1, 1'b1));
    // UDP whose updated checksum comes out zero and must read back as all ones.
    for (int c = 0; c < 65536; c++) begin
      if (csum_adjust(16'(c), 32'h0A01_0203, 32'hC0A8_0203, 1'b0) == 16'h0) begin
        zero_hit = 16'(c);
        break;
      end
    end
    queue_header(hdr(1'b0, PROTO_UDP, 32'h0A01_0203, 32'h0505_0505, 16'h0000, zero_hit,
                     1'b0, 1'b1));
    // Other protocols: address only, transport checksum reads zero.
    queue_header(hdr(1'b0, 8'd1, 32'h0A01_0203, 32'h0505_0505, 16'h1111, 16'hFFFF,
                     1'b0, 1'b0));
    queue_header(hdr(1'b1, 8'd255, 32'h0505_0505, 32'h7F00_0001, 16'h2222, 16'h1234,
                     1'b1, 1'b1));
    queue_header(hdr(1'b0, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF,
                     1'b0, 1'b1));
    // Missing transport header: short only when the address would change.
    queue_header(hdr(1'b0, PROTO_TCP, 32'h0A01_0203, 32'h0505_0505, 16'h3333, 16'h4444,
                     1'b0, 1'b0));
    queue_header(hdr(1'b1, PROTO_UDP, 32'h0505_0505, 32'hC0A8_0101, 16'h3333, 16'h4444,
                     1'b0, 1'b0));
    // Address already inside the target prefix.
    queue_header(hdr(1'b0, PROTO_TCP, 32'hC0A8_1234, 32'h0505_0505, 16'h5555, 16'h6666,
                     1'b0, 1'b1));
    // Version and header length checks.
    h = hdr(1'b0, PROTO_TCP, 32'h0A01_0203, 32'h0505_0505, 16'h7777, 16'h8888, 1'b0, 1'b1);
    h.ip_version = 4'h0;
    queue_header(h);
    h.ip_version = 4'hF;
    queue_header(h);
    h.ip_version   = IPV4_VERSION;
    h.header_words = 4'd4;
    queue_header(h);
    h.header_words = 4'd0;
    queue_header(h);
    h.header_words = 4'd15;
    queue_header(h);
    // Fragment checks: MF, offset, all bits; DF and the reserved bit pass.
    h.frag_field = 16'h2000;
    queue_header(h);
    h.frag_field = 16'h1FFF;
    queue_header(h);
    h.frag_field = 16'hFFFF;
    queue_header(h);
    h.frag_field = 16'h4000;
    queue_header(h);
    h.frag_field = 16'h8000;
    queue_header(h);
    drain();

    // Full mask, zero prefix: every address maps to zero. A partial-mode UDP
    // sum from all ones with a zero field folds to zero.
    set_netmap(32'hFFFF_FFFF, 32'h0000_0000);
    queue_header(hdr(1'b0, PROTO_UDP, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 16'h0000,
                     1'b1, 1'b1));
    queue_header(hdr(1'b1, PROTO_TCP, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                     1'b0, 1'b1));
    drain();

    // Random phases, each under its own setting; drained in between.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_netmap(32'hFFFF_FF00, 32'hC0A8_0100);
        1: set_netmap(32'hFFFF_FFFF, $urandom());
        2: set_netmap(32'h0000_0000, 32'hFFFF_FFFF);
        3: set_netmap(32'hFFFF_0000, 32'h0A00_0000);
        4: set_netmap($urandom(), $urandom());
        5: set_netmap(~(32'hFFFF_FFFF >> $urandom_range(32, 0)), $urandom());
        default: set_netmap(32'h0000_0000, 32'h0000_0000);
      endcase
      // One phase runs back to back with no idle on either side.
      steady = (ph == 3);
      repeat (175) queue_header(make_header());
      drain();
      steady = 1'b0;
    end

    repeat (6) @(posedge clk_i);
    if (error_cnt == 0 && expected_rewrites.size() == 0) begin
      $display("ipv4_prefix_netmap_rewrite regression: pass");
    end else begin
      $display("ipv4_prefix_netmap_rewrite regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("ipv4_prefix_netmap_rewrite regression: fail");
    $finish;
  end

endmodule
